// ===== hdl/vhfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel hidden-face culling package
// Field widths, codes and default limits shared by the culling block.
// ----------------------------------------------------------------------------
package vhfc_pkg;

    // Default grid limits, handed to the top level as parameter defaults.
    localparam int DEF_MAX_X = 1024;
    localparam int DEF_MAX_Y = 256;
    localparam int DEF_MAX_Z = 16;

    // Grid size after reset.
    localparam int DEF_SIZE = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_X      = 2'd0,
        REG_SIZE_Y      = 2'd1,
        REG_SIZE_Z      = 2'd2,
        REG_CULL_BORDER = 2'd3
    } cfg_reg_t;

    // Input command codes.
    typedef enum logic {
        CMD_VOXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // Result field widths.
    localparam int POS_X_W  = 10;
    localparam int POS_Y_W  = 8;
    localparam int POS_Z_W  = 4;
    localparam int FACES    = 6;
    localparam int CULLED_W = 3;
    localparam int SUM_W    = 25;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Face bit positions in the kept-face mask.
    localparam int FACE_PX = 0;
    localparam int FACE_PY = 1;
    localparam int FACE_PZ = 2;
    localparam int FACE_MZ = 3;
    localparam int FACE_MX = 4;
    localparam int FACE_MY = 5;

endpackage
`default_nettype wire

// ===== hdl/voxel_hidden_face_cull.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel hidden-face culling
// Streams voxels in x, y, z scan order and drops every face of a present
// cube whose neighbour occludes, keeping a two-plane window in memory.
// ----------------------------------------------------------------------------
//
//  Channel  Dir   Handshake              Payload
//  cfg      in    cfg_write              cfg_index, cfg_data
//  in       in    in_valid / in_stall    command, present, occluder
//  out      out   out_valid / out_stall  pos_x, pos_y, pos_z, voxel_present,
//                                        kept_faces, culled_here,
//                                        culled_total, last
//
//  One input transfer and one output transfer per cycle while out_stall is low.
//  A result passes the input register, the window memory read and the result
//  register after the input transfer that causes it. The +x neighbour is the
//  incoming voxel; the other five neighbour flags and the voxel's own presence
//  come from six window memories, each with one read and one write per cycle.
//  The result for a voxel is caused by the voxel one x-plane ahead,
//  or by a flush tick once the grid is complete.
//  Reset needs no clearing pass: a window entry is only read after it has been
//  written within the current grid.
//  A stalled output holds all three stages; the input stalls only when the
//  input register, the read stage and the result register are all full.
//
module voxel_hidden_face_cull #(
    parameter int MAX_X = vhfc_pkg::DEF_MAX_X,
    parameter int MAX_Y = vhfc_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vhfc_pkg::DEF_MAX_Z
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_write,
    input  wire logic [vhfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vhfc_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire vhfc_pkg::cmd_t                  command,
    input  wire logic                            present,
    input  wire logic                            occluder,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [vhfc_pkg::POS_X_W-1:0]         pos_x,
    output logic [vhfc_pkg::POS_Y_W-1:0]         pos_y,
    output logic [vhfc_pkg::POS_Z_W-1:0]         pos_z,
    output logic                                 voxel_present,
    output logic [vhfc_pkg::FACES-1:0]           kept_faces,
    output logic [vhfc_pkg::CULLED_W-1:0]        culled_here,
    output logic [vhfc_pkg::SUM_W-1:0]           culled_total,
    output logic                                 last
);
    import vhfc_pkg::*;

    localparam int XW = $clog2(MAX_X + 1);
    localparam int YW = $clog2(MAX_Y + 1);
    localparam int ZW = $clog2(MAX_Z + 1);
    // The window spans two planes plus one voxel; a power-of-two ring keeps
    // every live entry apart.
    localparam int AW    = $clog2(2 * MAX_Y * MAX_Z + 1);
    localparam int DEPTH = 1 << AW;
    localparam int PW    = YW + ZW;

    localparam int RST_X = (DEF_SIZE > MAX_X) ? MAX_X : DEF_SIZE;
    localparam int RST_Y = (DEF_SIZE > MAX_Y) ? MAX_Y : DEF_SIZE;
    localparam int RST_Z = (DEF_SIZE > MAX_Z) ? MAX_Z : DEF_SIZE;

    // Window memories behind the +y, +z, -z, -x and -y faces.
    localparam int N_OCC_MEM = FACES - 1;

    typedef struct packed {
        logic [FACES-1:0]     border;
        logic [N_OCC_MEM-1:0] occ_hit;
        logic                 pres_hit;
        logic                 cur_occ;
        logic                 cur_pres;
        logic                 last;
    } s1_ctl_t;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [XW-1:0] size_x_reg;
    logic [YW-1:0] size_y_reg;
    logic [ZW-1:0] size_z_reg;
    logic          cull_border_reg;
    logic [AW-1:0] plane_reg;
    logic [PW-1:0] plane_prod;
    logic [XW-1:0] size_x_new;
    logic [YW-1:0] size_y_new;
    logic [ZW-1:0] size_z_new;
    logic          cfg_restart;

    always_comb
    begin
        size_x_new = (cfg_data == '0) ? XW'(1) :
                     (32'(cfg_data) > MAX_X) ? XW'(MAX_X) : XW'(cfg_data);
        size_y_new = (cfg_data == '0) ? YW'(1) :
                     (32'(cfg_data) > MAX_Y) ? YW'(MAX_Y) : YW'(cfg_data);
        size_z_new = (cfg_data == '0) ? ZW'(1) :
                     (32'(cfg_data) > MAX_Z) ? ZW'(MAX_Z) : ZW'(cfg_data);
        cfg_restart = cfg_write &&
                      (cfg_index inside {REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z});
    end

    assign plane_prod = PW'(size_y_reg) * PW'(size_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg      <= XW'(RST_X);
            size_y_reg      <= YW'(RST_Y);
            size_z_reg      <= ZW'(RST_Z);
            cull_border_reg <= 1'b0;
            plane_reg       <= AW'(RST_Y * RST_Z);
        end
        else
        begin
            plane_reg <= AW'(plane_prod);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SIZE_X:      size_x_reg      <= size_x_new;
                    REG_SIZE_Y:      size_y_reg      <= size_y_new;
                    REG_SIZE_Z:      size_z_reg      <= size_z_new;
                    REG_CULL_BORDER: cull_border_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s1_ready;
    logic s0_ready;
    logic consume;
    logic s1_fire;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;
    assign consume   = s0_valid_reg && s1_ready;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign in_stall  = !s0_ready;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    cmd_t s0_cmd_reg;
    logic s0_present_reg;
    logic s0_occluder_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s0_ready)
        begin
            s0_cmd_reg      <= command;
            s0_present_reg  <= present;
            s0_occluder_reg <= occluder;
        end
    end

    // ------------------------------------------------------------------
    // Grid bookkeeping
    // ------------------------------------------------------------------
    logic [XW-1:0] in_x_reg, in_x_next, out_x_reg, out_x_next;
    logic [YW-1:0] in_y_reg, in_y_next, out_y_reg, out_y_next;
    logic [ZW-1:0] in_z_reg, in_z_next, out_z_reg, out_z_next;
    logic [AW-1:0] in_pos_reg, in_pos_next, out_pos_reg, out_pos_next;
    logic          in_done_reg, in_done_next;

    logic [XW-1:0] sx_m1;
    logic [YW-1:0] sy_m1;
    logic [ZW-1:0] sz_m1;
    logic          is_voxel;
    logic          wr;
    logic          emit;
    logic          in_last;
    logic          out_last;
    logic          cur_occ;
    logic [FACES-1:0] border;

    always_comb
    begin
        sx_m1    = size_x_reg - XW'(1);
        sy_m1    = size_y_reg - YW'(1);
        sz_m1    = size_z_reg - ZW'(1);
        is_voxel = (s0_cmd_reg == CMD_VOXEL);
        wr       = is_voxel && !in_done_reg;
        // A voxel emits once the input runs a whole plane ahead of the output.
        emit     = (wr && (in_x_reg != '0)) || (!is_voxel && in_done_reg);
        in_last  = (in_x_reg == sx_m1) && (in_y_reg == sy_m1) && (in_z_reg == sz_m1);
        out_last = (out_x_reg == sx_m1) && (out_y_reg == sy_m1) && (out_z_reg == sz_m1);
        cur_occ  = s0_occluder_reg && s0_present_reg;

        border[FACE_PX] = (out_x_reg == sx_m1);
        border[FACE_PY] = (out_y_reg == sy_m1);
        border[FACE_PZ] = (out_z_reg == sz_m1);
        border[FACE_MZ] = (out_z_reg == '0);
        border[FACE_MX] = (out_x_reg == '0);
        border[FACE_MY] = (out_y_reg == '0);
    end

    always_comb
    begin
        in_x_next    = in_x_reg;
        in_y_next    = in_y_reg;
        in_z_next    = in_z_reg;
        in_pos_next  = in_pos_reg;
        in_done_next = in_done_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_z_next   = out_z_reg;
        out_pos_next = out_pos_reg;

        if (cfg_restart)
        begin
            in_x_next    = '0;
            in_y_next    = '0;
            in_z_next    = '0;
            in_pos_next  = '0;
            in_done_next = 1'b0;
            out_x_next   = '0;
            out_y_next   = '0;
            out_z_next   = '0;
            out_pos_next = '0;
        end
        else if (consume)
        begin
            if (wr)
            begin
                in_pos_next = in_pos_reg + AW'(1);
                if (in_last)
                begin
                    in_done_next = 1'b1;
                end
                else if (in_z_reg == sz_m1)
                begin
                    in_z_next = '0;
                    if (in_y_reg == sy_m1)
                    begin
                        in_y_next = '0;
                        in_x_next = in_x_reg + XW'(1);
                    end
                    else
                    begin
                        in_y_next = in_y_reg + YW'(1);
                    end
                end
                else
                begin
                    in_z_next = in_z_reg + ZW'(1);
                end
            end

            if (emit)
            begin
                if (out_last)
                begin
                    // The final result of the grid starts the next one afresh.
                    in_x_next    = '0;
                    in_y_next    = '0;
                    in_z_next    = '0;
                    in_pos_next  = '0;
                    in_done_next = 1'b0;
                    out_x_next   = '0;
                    out_y_next   = '0;
                    out_z_next   = '0;
                    out_pos_next = '0;
                end
                else
                begin
                    out_pos_next = out_pos_reg + AW'(1);
                    if (out_z_reg == sz_m1)
                    begin
                        out_z_next = '0;
                        if (out_y_reg == sy_m1)
                        begin
                            out_y_next = '0;
                            out_x_next = out_x_reg + XW'(1);
                        end
                        else
                        begin
                            out_y_next = out_y_reg + YW'(1);
                        end
                    end
                    else
                    begin
                        out_z_next = out_z_reg + ZW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_x_reg    <= '0;
            in_y_reg    <= '0;
            in_z_reg    <= '0;
            in_pos_reg  <= '0;
            in_done_reg <= 1'b0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            out_z_reg   <= '0;
            out_pos_reg <= '0;
        end
        else
        begin
            in_x_reg    <= in_x_next;
            in_y_reg    <= in_y_next;
            in_z_reg    <= in_z_next;
            in_pos_reg  <= in_pos_next;
            in_done_reg <= in_done_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            out_z_reg   <= out_z_next;
            out_pos_reg <= out_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Window memories
    // ------------------------------------------------------------------
    logic [AW-1:0]        sz_a;
    logic [AW-1:0]        occ_raddr [N_OCC_MEM];
    logic [N_OCC_MEM-1:0] occ_hit;
    logic [N_OCC_MEM-1:0] occ_q;
    logic                 pres_hit;
    logic                 pres_q_reg;
    logic                 pres_mem [DEPTH];

    // Read addresses, in face order +y, +z, -z, -x, -y. The +x neighbour is
    // the voxel arriving now and needs no read.
    always_comb
    begin
        sz_a         = AW'(size_z_reg);
        occ_raddr[0] = out_pos_reg + sz_a;
        occ_raddr[1] = out_pos_reg + AW'(1);
        occ_raddr[2] = out_pos_reg - AW'(1);
        occ_raddr[3] = out_pos_reg - plane_reg;
        occ_raddr[4] = out_pos_reg - sz_a;
        pres_hit     = wr && (out_pos_reg == in_pos_reg);
    end

    // The memories return the old entry when read and written together, so a
    // neighbour written in the same transfer is taken from the input instead.
    for (genvar t = 0; t < N_OCC_MEM; t++)
    begin : g_occ_mem
        logic occ_mem [DEPTH];
        logic occ_q_reg;

        assign occ_hit[t] = wr && (occ_raddr[t] == in_pos_reg);
        assign occ_q[t]   = occ_q_reg;

        always_ff @(posedge clk)
        begin
            if (consume)
            begin
                occ_q_reg <= occ_mem[occ_raddr[t]];
                if (wr)
                begin
                    occ_mem[in_pos_reg] <= cur_occ;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            pres_q_reg <= pres_mem[out_pos_reg];
            if (wr)
            begin
                pres_mem[in_pos_reg] <= s0_present_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Read stage
    // ------------------------------------------------------------------
    s1_ctl_t       s1_ctl_reg;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    logic [ZW-1:0] s1_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            s1_x_reg            <= out_x_reg;
            s1_y_reg            <= out_y_reg;
            s1_z_reg            <= out_z_reg;
            s1_ctl_reg.border   <= border;
            s1_ctl_reg.occ_hit  <= occ_hit;
            s1_ctl_reg.pres_hit <= pres_hit;
            s1_ctl_reg.cur_occ  <= cur_occ;
            s1_ctl_reg.cur_pres <= s0_present_reg;
            s1_ctl_reg.last     <= out_last;
        end
    end

    // ------------------------------------------------------------------
    // Face decision
    // ------------------------------------------------------------------
    logic                s1_pres;
    logic [FACES-1:0]    nb_occ;
    logic [FACES-1:0]    drop;
    logic [FACES-1:0]    kept;
    logic [CULLED_W-1:0] culled;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic [SUM_W-1:0]    culled_sum_reg;

    always_comb
    begin
        s1_pres = s1_ctl_reg.pres_hit ? s1_ctl_reg.cur_pres : pres_q_reg;
        nb_occ[FACE_PX] = s1_ctl_reg.cur_occ;
        for (int t = 0; t < N_OCC_MEM; t++)
        begin
            nb_occ[t + 1] = s1_ctl_reg.occ_hit[t] ? s1_ctl_reg.cur_occ : occ_q[t];
        end
        for (int f = 0; f < FACES; f++)
        begin
            drop[f] = s1_ctl_reg.border[f] ? cull_border_reg : nb_occ[f];
        end

        kept   = '0;
        culled = '0;
        if (s1_pres)
        begin
            kept = ~drop;
            for (int f = 0; f < FACES; f++)
            begin
                culled = culled + CULLED_W'(drop[f]);
            end
        end

        sum_wide = (SUM_W + 1)'(culled_sum_reg) + (SUM_W + 1)'(culled);
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            culled_sum_reg <= '0;
        end
        else if (cfg_restart)
        begin
            culled_sum_reg <= '0;
        end
        else if (s1_fire)
        begin
            culled_sum_reg <= s1_ctl_reg.last ? '0 : sum_sat;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [POS_X_W-1:0]  pos_x_reg;
    logic [POS_Y_W-1:0]  pos_y_reg;
    logic [POS_Z_W-1:0]  pos_z_reg;
    logic                present_reg;
    logic [FACES-1:0]    kept_reg;
    logic [CULLED_W-1:0] culled_reg;
    logic [SUM_W-1:0]    total_reg;
    logic                last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            pos_x_reg   <= POS_X_W'(s1_x_reg);
            pos_y_reg   <= POS_Y_W'(s1_y_reg);
            pos_z_reg   <= POS_Z_W'(s1_z_reg);
            present_reg <= s1_pres;
            kept_reg    <= kept;
            culled_reg  <= culled;
            total_reg   <= sum_sat;
            last_reg    <= s1_ctl_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_z         = pos_z_reg;
    assign voxel_present = present_reg;
    assign kept_faces    = kept_reg;
    assign culled_here   = culled_reg;
    assign culled_total  = total_reg;
    assign last          = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (s0_valid_reg && s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free pipeline stage");

    a_faces_add_up: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && present_reg) |->
            ($countones(kept_reg) + int'(culled_reg) == FACES))
        else $error("kept and culled faces of a cube do not add up to six");

    a_empty_voxel: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !present_reg) |-> (kept_reg == '0 && culled_reg == '0))
        else $error("empty voxel reports faces");

    a_grid_restart: assert property (
        @(posedge clk) disable iff (!rst_n)
        (consume && emit && out_last) |=>
            (!in_done_reg && in_pos_reg == '0 && out_pos_reg == '0))
        else $error("grid did not restart after its final voxel");

    a_sum_monotonic: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_ctl_reg.last && !cfg_restart) |=>
            (culled_sum_reg >= $past(culled_sum_reg)))
        else $error("running culled total decreased within a grid");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the voxel hidden-face culling block
// Streams voxel grids of many shapes through the block, predicts every
// kept-face result in step with the input transfers and checks each output
// transfer field by field, under several patterns of sender idling and
// receiver stalling.
// ----------------------------------------------------------------------------
module tb;

    import vhfc_pkg::*;

    localparam int WIN_DEPTH = 2 * DEF_MAX_Y * DEF_MAX_Z + 1;
    // A result passes the input, read and result registers; allow a margin.
    localparam int HOLD_OFF  = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_ROWS  = 30;

    typedef struct packed {
        logic [POS_X_W-1:0]  x;
        logic [POS_Y_W-1:0]  y;
        logic [POS_Z_W-1:0]  z;
        logic                pres;
        logic [FACES-1:0]    kept;
        logic [CULLED_W-1:0] culled;
        logic [SUM_W-1:0]    total;
        logic                last;
    } cull_result_t;

    typedef struct packed {
        logic                  is_cfg;
        cfg_reg_t              reg_idx;
        logic [CFG_DATA_W-1:0] value;
        cmd_t                  cmd;
        logic                  pres;
        logic                  occ;
        logic                  typed;
        cull_result_t          want;
    } stim_row_t;

    localparam cull_result_t NO_RESULT   = '0;
    // Single-voxel grids: every face lies on the border.
    localparam cull_result_t SOLO_HIDDEN =
        '{10'd0, 8'd0, 4'd0, 1'b1, 6'h00, 3'd6, 25'd6, 1'b1};
    localparam cull_result_t SOLO_EMPTY  =
        '{10'd0, 8'd0, 4'd0, 1'b0, 6'h00, 3'd0, 25'd0, 1'b1};
    localparam cull_result_t SOLO_OPEN   =
        '{10'd0, 8'd0, 4'd0, 1'b1, 6'h3F, 3'd0, 25'd0, 1'b1};

    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        // Sizes of zero clamp to a single voxel.
        '{1'b1, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, REG_SIZE_Y,      11'd0, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, REG_SIZE_Z,      11'd0, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, REG_CULL_BORDER, 11'd1, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b0, 1'b0, 1'b1, SOLO_HIDDEN},
        // Flush with nothing pending.
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b1, 1'b1, 1'b0, NO_RESULT},
        // Occluder flag without a cube.
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b0, 1'b0, 1'b1, SOLO_EMPTY},
        '{1'b1, REG_CULL_BORDER, 11'd0, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b1, 1'b0, 1'b1, SOLO_OPEN},
        // A 2x2x2 grid with an early flush and a surplus voxel.
        '{1'b1, REG_SIZE_X,      11'd2, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, REG_SIZE_Y,      11'd2, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b1, REG_SIZE_Z,      11'd2, CMD_VOXEL, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_VOXEL, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{1'b0, REG_SIZE_X,      11'd0, CMD_FLUSH, 1'b0, 1'b0, 1'b0, NO_RESULT}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    cmd_t                  command   = CMD_VOXEL;
    logic                  present   = 1'b0;
    logic                  occluder  = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [POS_X_W-1:0]    pos_x;
    logic [POS_Y_W-1:0]    pos_y;
    logic [POS_Z_W-1:0]    pos_z;
    logic                  voxel_present;
    logic [FACES-1:0]      kept_faces;
    logic [CULLED_W-1:0]   culled_here;
    logic [SUM_W-1:0]      culled_total;
    logic                  last;

    voxel_hidden_face_cull DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .present       (present),
        .occluder      (occluder),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .voxel_present (voxel_present),
        .kept_faces    (kept_faces),
        .culled_here   (culled_here),
        .culled_total  (culled_total),
        .last          (last)
    );

    always #5 clk = ~clk;

    // Mirror of the block: sizes, two-plane window and scan positions.
    int unsigned  grid_x = DEF_SIZE;
    int unsigned  grid_y = DEF_SIZE;
    int unsigned  grid_z = DEF_SIZE;
    logic         border_on = 1'b0;
    logic [1:0]   win [WIN_DEPTH];
    int unsigned  voxels_in = 0;
    int unsigned  voxels_out = 0;
    int unsigned  at_x = 0;
    int unsigned  at_y = 0;
    int unsigned  at_z = 0;
    int unsigned  faces_culled = 0;

    cull_result_t faces_due [$];
    int           mismatches = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;

    function automatic void restart_grid();
        voxels_in    = 0;
        voxels_out   = 0;
        at_x         = 0;
        at_y         = 0;
        at_z         = 0;
        faces_culled = 0;
    endfunction

    function automatic void load_grid_reg(cfg_reg_t idx, int unsigned value);
        case (idx)
            REG_SIZE_X:
            begin
                grid_x = (value < 1) ? 1 : (value > DEF_MAX_X) ? DEF_MAX_X : value;
                restart_grid();
            end
            REG_SIZE_Y:
            begin
                grid_y = (value < 1) ? 1 : (value > DEF_MAX_Y) ? DEF_MAX_Y : value;
                restart_grid();
            end
            REG_SIZE_Z:
            begin
                grid_z = (value < 1) ? 1 : (value > DEF_MAX_Z) ? DEF_MAX_Z : value;
                restart_grid();
            end
            default:
                border_on = value[0];
        endcase
    endfunction

    function automatic void emit_face_result();
        int unsigned      plane;
        int unsigned      total;
        int unsigned      p;
        logic [FACES-1:0] drop;
        cull_result_t     r;
        plane = grid_y * grid_z;
        total = grid_x * plane;
        p     = voxels_out;
        drop  = '0;
        r.pres = win[p % WIN_DEPTH][0];
        // A border face is dropped by the border setting, an inner one by its
        // neighbour's occlusion flag.
        if (r.pres)
        begin
            drop[FACE_PX] = (at_x + 1 >= grid_x) ? border_on : win[(p + plane) % WIN_DEPTH][1];
            drop[FACE_PY] = (at_y + 1 >= grid_y) ? border_on : win[(p + grid_z) % WIN_DEPTH][1];
            drop[FACE_PZ] = (at_z + 1 >= grid_z) ? border_on : win[(p + 1) % WIN_DEPTH][1];
            drop[FACE_MZ] = (at_z == 0) ? border_on : win[(p - 1) % WIN_DEPTH][1];
            drop[FACE_MX] = (at_x == 0) ? border_on : win[(p - plane) % WIN_DEPTH][1];
            drop[FACE_MY] = (at_y == 0) ? border_on : win[(p - grid_z) % WIN_DEPTH][1];
        end
        r.kept   = r.pres ? ~drop : '0;
        r.culled = CULLED_W'($countones(drop));
        faces_culled = faces_culled + r.culled;
        if (faces_culled > SUM_MAX)
            faces_culled = SUM_MAX;
        r.x     = at_x[POS_X_W-1:0];
        r.y     = at_y[POS_Y_W-1:0];
        r.z     = at_z[POS_Z_W-1:0];
        r.total = faces_culled[SUM_W-1:0];
        r.last  = (p + 1 == total);
        faces_due.push_back(r);
        if (r.last)
            restart_grid();
        else
        begin
            voxels_out = p + 1;
            at_z++;
            if (at_z >= grid_z)
            begin
                at_z = 0;
                at_y++;
                if (at_y >= grid_y)
                begin
                    at_y = 0;
                    at_x++;
                end
            end
        end
    endfunction

    function automatic void predict_cull(cmd_t cmd, logic pres, logic occ);
        int unsigned plane;
        int unsigned total;
        plane = grid_y * grid_z;
        total = grid_x * plane;
        if (cmd == CMD_FLUSH)
        begin
            if (voxels_in >= total && voxels_out < total)
                emit_face_result();
        end
        else if (voxels_in < total)
        begin
            win[voxels_in % WIN_DEPTH] = {occ & pres, pres};
            voxels_in++;
            if (voxels_in > voxels_out + plane)
                emit_face_result();
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transfer, with valid still high.
    task automatic send_item(cmd_t cmd, logic pres, logic occ);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        present  <= pres;
        occluder <= occ;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic feed(cmd_t cmd);
        logic pres;
        logic occ;
        pres = ($urandom_range(0, 99) < 75);
        occ  = ($urandom_range(0, 99) < 70);
        predict_cull(cmd, pres, occ);
        send_item(cmd, pres, occ);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        load_grid_reg(idx, value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every expected result is out and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        while (faces_due.size() != 0)
            @(negedge clk);
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    task automatic run_grid(logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy,
                            logic [CFG_DATA_W-1:0] sz, logic cb, int mode, bit cut_short);
        int unsigned n;
        settle();
        case (mode % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 68; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 21; stall_pct = 21; end
        endcase
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        write_reg(REG_CULL_BORDER, {{(CFG_DATA_W-1){1'b0}}, cb});
        n = grid_x * grid_y * grid_z;
        // A grid cut short is abandoned; the next size write restarts it.
        if (cut_short)
            n = $urandom_range(0, n - 1);
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                feed(CMD_FLUSH);
            feed(CMD_VOXEL);
        end
        if (!cut_short)
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) feed(CMD_VOXEL);
            while (voxels_in >= grid_x * grid_y * grid_z)
                feed(CMD_FLUSH);
            if ($urandom_range(0, 3) == 0)
                feed(CMD_FLUSH);
        end
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        cull_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (faces_due.size() == 0)
            begin
                $display("%0t: result for (%0d,%0d,%0d) with none expected",
                         $time, pos_x, pos_y, pos_z);
                mismatches++;
            end
            else
            begin
                want = faces_due.pop_front();
                check_field("pos_x", want.x, pos_x);
                check_field("pos_y", want.y, pos_y);
                check_field("pos_z", want.z, pos_z);
                check_field("voxel_present", want.pres, voxel_present);
                check_field("kept_faces", want.kept, kept_faces);
                check_field("culled_here", want.culled, culled_here);
                check_field("culled_total", want.total, culled_total);
                check_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        int        queued;
        foreach (win[i])
            win[i] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.reg_idx, row.value);
            end
            else
            begin
                queued = faces_due.size();
                predict_cull(row.cmd, row.pres, row.occ);
                if (row.typed)
                begin
                    if (faces_due.size() > queued)
                        void'(faces_due.pop_back());
                    faces_due.push_back(row.want);
                end
                send_item(row.cmd, row.pres, row.occ);
            end
        end

        // Extremes: longest x, longest y, deepest z; sizes written above range.
        run_grid(11'd2047, 11'd1, 11'd1, 1'b1, 3, 1'b0);
        run_grid(11'd1, 11'd511, 11'd1, 1'b0, 1, 1'b0);
        run_grid(11'd2, 11'd2, 11'd31, 1'b1, 2, 1'b0);
        for (int g = 0; g < 16; g++)
            run_grid($urandom_range(1, 3), $urandom_range(1, 3),
                     ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 6),
                     $urandom_range(0, 1), g, $urandom_range(0, 4) == 0);

        settle();
        if (mismatches == 0 && faces_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
